### sv/csmi_pkg.sv
// Package for the column span merge/insert block: sizes, status codes, item types.
// No dependencies; imported by every module of the block.
package csmi_pkg;

    localparam int MAX_COLUMNS      = 4096;
    localparam int SPANS_PER_COLUMN = 8;

    localparam int COL_W   = $clog2(MAX_COLUMNS);
    localparam int SLOT_W  = (SPANS_PER_COLUMN > 1) ? $clog2(SPANS_PER_COLUMN) : 1;
    localparam int CNT_W   = $clog2(SPANS_PER_COLUMN + 1);
    localparam int ADDR_W  = $clog2(MAX_COLUMNS * SPANS_PER_COLUMN);
    localparam int FULLC_W = 26;   // x + z * grid_width before the range check

    // result status codes
    localparam logic [1:0] ST_STORED = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_RANGE  = 2'd3;

    // configuration register indexes
    localparam logic CFG_GRID_WIDTH = 1'b0;
    localparam logic CFG_MERGE_THR  = 1'b1;

    typedef struct packed {
        logic [15:0] low;
        logic [15:0] high;
        logic [7:0]  area;
    } t_span;

    // classified word handed from front to back
    typedef struct packed {
        logic             empty_span;
        logic             in_range;
        logic [COL_W-1:0] col;
        t_span            span;
    } t_item;

endpackage

### sv/column_span_merge_insert_top.sv
// Top level of the column span merge/insert block.
// Depends on csmi_pkg, csmi_front, csmi_queue, csmi_back.
//
// Input channel (i_valid/o_ready) takes one span word per column: x, z, low,
// high and area id. Output channel (o_valid/i_ready) returns one result word
// for each input word, in order: status, merged span and column count.
// Config writes (i_cfg_we, i_cfg_idx, i_cfg_wdata) set grid width (index 0)
// and merge threshold (index 1); write them only while the block is idle.
//
// The front registers the column index, classifies the word and pushes it
// into a two-entry queue. The back reads the column count, loads the
// column's spans, merges them one span a cycle, writes the merged list back
// and presents the result. An empty or out-of-range word skips the load,
// merge and write-back; a full column is loaded and scanned but not written
// back. The front register holds each word on its way into the queue.
// After reset the count memory is cleared, one column a cycle; until that is
// done the back takes nothing and only three words fit in front and queue.
// A stalled receiver holds the result register; the back waits, the queue fills.
module column_span_merge_insert_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [11:0] i_column_x,
    input  logic [11:0] i_column_z,
    input  logic [15:0] i_span_low,
    input  logic [15:0] i_span_high,
    input  logic [7:0]  i_area_id,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_merged_low,
    output logic [15:0] o_merged_high,
    output logic [7:0]  o_merged_area,
    output logic [3:0]  o_column_count,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);
    import csmi_pkg::*;

    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_nempty;
    t_item f_item;
    t_item q_item;

    csmi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_column_x  (i_column_x),
        .i_column_z  (i_column_z),
        .i_span_low  (i_span_low),
        .i_span_high (i_span_high),
        .i_area_id   (i_area_id),
        .i_gw_we     (i_cfg_we && (i_cfg_idx == CFG_GRID_WIDTH)),
        .i_gw_data   (i_cfg_wdata[12:0]),
        .o_push      (push),
        .o_item      (f_item),
        .i_q_full    (q_full)
    );

    csmi_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (f_item),
        .o_full   (q_full),
        .i_pop    (pop),
        .o_nempty (q_nempty),
        .o_item   (q_item)
    );

    csmi_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_thr_we       (i_cfg_we && (i_cfg_idx == CFG_MERGE_THR)),
        .i_thr_data     (i_cfg_wdata),
        .i_q_nempty     (q_nempty),
        .i_q_item       (q_item),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_merged_low   (o_merged_low),
        .o_merged_high  (o_merged_high),
        .o_merged_area  (o_merged_area),
        .o_column_count (o_column_count)
    );

endmodule

### sv/csmi_front.sv
// Front part: accepts input words, forms the column index and classifies them.
// Depends on csmi_pkg.
module csmi_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [11:0]      i_column_x,
    input  logic [11:0]      i_column_z,
    input  logic [15:0]      i_span_low,
    input  logic [15:0]      i_span_high,
    input  logic [7:0]       i_area_id,
    input  logic             i_gw_we,
    input  logic [12:0]      i_gw_data,
    output logic             o_push,
    output csmi_pkg::t_item  o_item,
    input  logic             i_q_full
);
    import csmi_pkg::*;

    logic [12:0]        r_grid_width;
    logic               r_valid;
    logic [FULLC_W-1:0] r_col;
    t_span              r_span;
    logic [FULLC_W-1:0] n_col;

    // column index; the product is registered before the range check
    assign n_col = FULLC_W'(i_column_x) + FULLC_W'(i_column_z) * FULLC_W'(r_grid_width);

    assign o_push  = r_valid && !i_q_full;
    assign o_ready = !r_valid || o_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width <= 13'd64;
        end else if (i_gw_we) begin
            r_grid_width <= i_gw_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_col  <= n_col;
            r_span <= '{low: i_span_low, high: i_span_high, area: i_area_id};
        end
    end

    // classification
    always_comb begin
        o_item.empty_span = (r_span.low >= r_span.high);
        o_item.in_range   = (r_col < FULLC_W'(MAX_COLUMNS));
        o_item.col        = r_col[COL_W-1:0];
        o_item.span       = r_span;
    end

endmodule

### sv/csmi_queue.sv
// Two-entry queue of classified words between front and back.
// Depends on csmi_pkg.
module csmi_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  csmi_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_nempty,
    output csmi_pkg::t_item o_item
);
    import csmi_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_n;

    assign o_full   = (r_n == 2'd2);
    assign o_nempty = (r_n != 2'd0);
    assign o_item   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_n  <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            case ({i_push, i_pop})
                2'b10:   r_n <= r_n + 2'd1;
                2'b01:   r_n <= r_n - 2'd1;
                default: r_n <= r_n;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

endmodule

### sv/csmi_back.sv
// Back part: per-column count and span memories, load/merge/write-back sequencer,
// and the result register. Depends on csmi_pkg.
module csmi_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_thr_we,
    input  logic [15:0]     i_thr_data,
    input  logic            i_q_nempty,
    input  csmi_pkg::t_item i_q_item,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [1:0]      o_status,
    output logic [15:0]     o_merged_low,
    output logic [15:0]     o_merged_high,
    output logic [7:0]      o_merged_area,
    output logic [3:0]      o_column_count
);
    import csmi_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CNT   = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // memories
    logic [CNT_W-1:0] cnt_mem [MAX_COLUMNS];
    t_span            st_mem  [MAX_COLUMNS * SPANS_PER_COLUMN];

    logic [2:0]       r_state;
    logic [15:0]      r_thr;
    logic [COL_W-1:0] r_clr;
    logic             r_empty;
    logic             r_inr;
    logic [COL_W-1:0] r_col;
    t_span            r_new;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_ld;
    logic [CNT_W-1:0] r_i;
    logic [CNT_W-1:0] r_before;
    logic [CNT_W-1:0] r_absorbed;
    logic [CNT_W-1:0] r_w;
    t_span            r_buf [SPANS_PER_COLUMN];
    logic [1:0]       r_status;
    logic [3:0]       r_outcnt;
    logic [CNT_W-1:0] r_cnt_rd;
    t_span            r_st_rd;
    logic             r_ovalid;
    logic [1:0]       r_o_status;
    t_span            r_o_span;
    logic [3:0]       r_o_count;

    logic [COL_W-1:0]  cnt_raddr;
    logic              cnt_we;
    logic [COL_W-1:0]  cnt_waddr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] st_raddr;
    logic              st_we;
    logic [ADDR_W-1:0] st_waddr;
    t_span             st_wdata;
    logic [CNT_W-1:0]  cnt_clip;
    t_span             cur;
    logic              scan_go;
    t_span             stepped;
    logic [CNT_W:0]    newcount;
    logic [CNT_W-1:0]  tail;
    logic [CNT_W-1:0]  tail_idx;
    logic              out_free;

    assign o_pop    = (r_state == S_IDLE) && i_q_nempty;
    assign out_free = !r_ovalid || i_ready;
    assign base     = ADDR_W'(r_col) * ADDR_W'(SPANS_PER_COLUMN);

    assign cnt_raddr = o_pop ? i_q_item.col : r_col;
    assign cnt_clip  = (r_cnt_rd > CNT_W'(SPANS_PER_COLUMN)) ?
                       CNT_W'(SPANS_PER_COLUMN) : r_cnt_rd;
    assign st_raddr  = base + ADDR_W'(r_ld);

    // one merge step against the stored span at r_i
    assign cur     = r_buf[r_i[SLOT_W-1:0]];
    assign scan_go = (r_i < r_cnt) && !(cur.low > r_new.high);
    always_comb begin
        stepped = r_new;
        if (cur.low < r_new.low)   stepped.low  = cur.low;
        if (cur.high > r_new.high) stepped.high = cur.high;
        if (((stepped.high - cur.high) <= r_thr) && (cur.area > r_new.area))
            stepped.area = cur.area;
    end

    assign newcount = CNT_W'(1) + {1'b0, r_cnt} - {1'b0, r_absorbed};
    assign tail     = r_cnt - r_i;
    assign tail_idx = r_i + r_w - CNT_W'(1);

    // write ports
    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = r_col;
        cnt_wdata = '0;
        st_we     = 1'b0;
        st_waddr  = base + ADDR_W'(r_before) + ADDR_W'(r_w);
        st_wdata  = (r_w == '0) ? r_new : r_buf[tail_idx[SLOT_W-1:0]];
        case (r_state)
            S_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_clr;
            end
            S_WRITE: begin
                st_we = 1'b1;
                if (r_w == tail) begin
                    cnt_we    = 1'b1;
                    cnt_wdata = newcount[CNT_W-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
        r_cnt_rd <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (st_we) st_mem[st_waddr] <= st_wdata;
        r_st_rd <= st_mem[st_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 16'd1;
        end else if (i_thr_we) begin
            r_thr <= i_thr_data;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + COL_W'(1);
                    if (r_clr == COL_W'(MAX_COLUMNS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_q_nempty) r_state <= S_CNT;
                end
                S_CNT: begin
                    if (r_empty || !r_inr) r_state <= S_DONE;
                    else                   r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (r_ld == r_cnt) r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (!scan_go) begin
                        if (newcount > (CNT_W+1)'(SPANS_PER_COLUMN)) r_state <= S_DONE;
                        else                                          r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (r_w == tail) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath of the sequencer
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_empty <= i_q_item.empty_span;
                r_inr   <= i_q_item.in_range;
                r_col   <= i_q_item.col;
                r_new   <= i_q_item.span;
            end
            S_CNT: begin
                r_cnt      <= cnt_clip;
                r_ld       <= '0;
                r_i        <= '0;
                r_before   <= '0;
                r_absorbed <= '0;
                r_w        <= '0;
                if (r_empty) begin
                    r_status <= ST_EMPTY;
                    r_outcnt <= r_inr ? 4'(r_cnt_rd) : 4'd0;
                end else begin
                    r_status <= ST_RANGE;
                    r_outcnt <= 4'd0;
                end
            end
            S_LOAD: begin
                // read issued at r_ld comes back registered in r_st_rd and is stored at r_ld-1
                if (r_ld != '0) r_buf[SLOT_W'(r_ld - CNT_W'(1))] <= r_st_rd;
                if (r_ld != r_cnt) r_ld <= r_ld + CNT_W'(1);
            end
            S_SCAN: begin
                if (scan_go) begin
                    r_i <= r_i + CNT_W'(1);
                    if (cur.high < r_new.low) begin
                        r_before <= r_before + CNT_W'(1);
                    end else begin
                        r_new      <= stepped;
                        r_absorbed <= r_absorbed + CNT_W'(1);
                    end
                end else begin
                    r_status <= ST_FULL;
                    r_outcnt <= 4'(r_cnt);
                end
            end
            S_WRITE: begin
                r_w      <= r_w + CNT_W'(1);
                r_status <= ST_STORED;
                r_outcnt <= 4'(newcount);
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_o_status <= r_status;
            r_o_count  <= r_outcnt;
            r_o_span   <= (r_status == ST_STORED) ? r_new : '0;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_o_status;
    assign o_merged_low   = r_o_span.low;
    assign o_merged_high  = r_o_span.high;
    assign o_merged_area  = r_o_span.area;
    assign o_column_count = r_o_count;

endmodule

### sv/csmi_checker.sv
// Port-level checker for the column span merge/insert block, bound to the top.
// Depends on csmi_pkg and column_span_merge_insert_top.
module csmi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic [15:0] o_merged_low,
    input logic [15:0] o_merged_high,
    input logic [7:0]  o_merged_area,
    input logic [3:0]  o_column_count
);
    import csmi_pkg::*;

    // a result stays valid with its status until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status))
        else $error("result word dropped or changed while stalled");

    // reset empties the result register
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a stored span is never empty
    a_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_STORED) |-> o_merged_low < o_merged_high)
        else $error("stored span is empty");

    // other outcomes carry no span
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_STORED) |->
            (o_merged_low == 16'd0) && (o_merged_high == 16'd0) &&
            (o_merged_area == 8'd0))
        else $error("span fields set without a store");

    // count never exceeds column capacity; a store leaves at least one span
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_column_count <= 4'(SPANS_PER_COLUMN)) &&
            ((o_status != ST_STORED) || (o_column_count != 4'd0)))
        else $error("column count out of bounds");

endmodule

bind column_span_merge_insert_top csmi_checker u_csmi_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_status       (o_status),
    .o_merged_low   (o_merged_low),
    .o_merged_high  (o_merged_high),
    .o_merged_area  (o_merged_area),
    .o_column_count (o_column_count)
);
